// ===== hdl/varint_number_encoder_top_assert.svh =====
// Assertion macros for the varint encoder top level.
`ifndef VARINT_NUMBER_ENCODER_TOP_ASSERT_SVH
`define VARINT_NUMBER_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// a implies b at the same edge
`define VNE_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// a implies b at the next edge
`define VNE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`else

`define VNE_ASSERT_NOW(label, clk, rst_n, a, b)
`define VNE_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== hdl/vne_pkg.sv =====
`default_nettype none

package vne_pkg;

	localparam int unsigned MAX_BYTES = 5;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QAW       = $clog2(QDEPTH);
	localparam int unsigned QCW       = $clog2(QDEPTH + 1);

	localparam logic [7:0] PREFIX_NEG = 8'd255;
	localparam logic [7:0] MAX_SHORT  = 8'd250;
	localparam logic [7:0] TAG_U8     = 8'd251;
	localparam logic [7:0] TAG_U16    = 8'd252;
	localparam logic [7:0] TAG_U32    = 8'd253;

	// one encoded number, first byte in the low bits
	typedef struct packed {
		logic [8*MAX_BYTES-1:0] bytes;
		logic [2:0]             count;
	} desc_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           full;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hdl/varint_number_encoder_top.sv =====
// Channel  | Dir | Data                     | Side band
// s_axis   | in  | tdata[31:0] value        | none
// m_axis   | out | tdata[7:0]  out_byte     | tlast is_last, tuser[2:0] total_bytes
//
// One number takes 1 to 5 output beats (its encoding length); the byte
// serializer in the back end sets the rate, one beat per cycle while m accepts.
// The front end takes one number per cycle while the 4-entry queue has room.
// The input passes through a queue entry register, then the output register.
// arst_n clears queue pointers, serializer busy and output valid, not data.
// A stalled m side fills the queue, then drops s_tready.
`default_nettype none
`include "varint_number_encoder_top_assert.svh"

module varint_number_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,
	output logic [2:0]       m_tuser    // [2:0] total_bytes
);
	import vne_pkg::*;

	logic      push;
	desc_t     push_desc;
	logic      pop;
	logic      head_valid;
	desc_t     head_desc;
	q_status_t q_status;

	// classify the number and build its byte string
	vne_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_status.full),
		.push      (push),
		.push_desc (push_desc)
	);

	// decouples intake from the byte serializer
	vne_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.status     (q_status)
	);

	// one byte per beat, count on the last one
	vne_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	// byte count only on the final beat
	`VNE_ASSERT_NOW(a_count_mid, clk, arst_n, m_tvalid && !m_tlast, m_tuser == 3'd0)
	`VNE_ASSERT_NOW(a_count_last, clk, arst_n, m_tvalid && m_tlast,
		(m_tuser != 3'd0) && (m_tuser <= 3'd5))
	// backpressure only from a full queue
	`VNE_ASSERT_NOW(a_ready_full, clk, arst_n, !s_tready, q_status.count == QCW'(QDEPTH))
	// a push into an almost-full queue without a pop fills it
	`VNE_ASSERT_NEXT(a_fill, clk, arst_n,
		push && !pop && (q_status.count == QCW'(QDEPTH - 1)), !s_tready)

endmodule

`default_nettype wire

// ===== hdl/vne_front.sv =====
`default_nettype none

module vne_front (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [31:0]   s_tdata,
	input  wire logic          q_full,
	output logic               push,
	output vne_pkg::desc_t     push_desc
);
	import vne_pkg::*;

	logic        neg_small;
	logic [31:0] w;
	logic [39:0] body;
	logic [2:0]  body_n;

	always_comb begin
		// -65536..-1: bits 31..16 all ones
		neg_small = &s_tdata[31:16];
		w = neg_small ? ~s_tdata : s_tdata;
		if (w <= {24'd0, MAX_SHORT}) begin
			body   = {32'd0, w[7:0]};
			body_n = 3'd1;
		end else if (w[31:8] == 24'd0) begin
			body   = {24'd0, w[7:0], TAG_U8};
			body_n = 3'd2;
		end else if (w[31:16] == 16'd0) begin
			body   = {16'd0, w[15:0], TAG_U16};
			body_n = 3'd3;
		end else begin
			body   = {w, TAG_U32};
			body_n = 3'd5;
		end
		// prefixed body is at most three bytes
		if (neg_small) begin
			push_desc.bytes = {body[31:0], PREFIX_NEG};
			push_desc.count = body_n + 3'd1;
		end else begin
			push_desc.bytes = body;
			push_desc.count = body_n;
		end
		s_tready = !q_full;
		push     = s_tvalid && !q_full;
	end

endmodule

`default_nettype wire

// ===== hdl/vne_queue.sv =====
`default_nettype none

module vne_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire vne_pkg::desc_t  push_desc,
	input  wire logic            pop,
	output logic                 head_valid,
	output vne_pkg::desc_t       head_desc,
	output vne_pkg::q_status_t   status
);
	import vne_pkg::*;

	desc_t          entry_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] count_q;

	always_comb begin
		head_valid   = count_q != QCW'(0);
		head_desc    = entry_q[rd_q];
		status.count = count_q;
		status.full  = count_q == QCW'(QDEPTH);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/vne_back.sv =====
`default_nettype none

module vne_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire vne_pkg::desc_t head_desc,
	output logic               pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast,
	output logic [2:0]         m_tuser
);
	import vne_pkg::*;

	logic                   busy_q;
	logic [8*MAX_BYTES-1:0] sh_q;
	logic [2:0]             rem_q;
	logic [2:0]             tot_q;
	logic                   valid_q;
	logic [7:0]             byte_q;
	logic                   last_q;
	logic [2:0]             total_q;

	logic                   fire;
	logic [8*MAX_BYTES-1:0] src_bytes;
	logic [2:0]             src_rem;
	logic [2:0]             src_tot;
	logic                   src_end;

	always_comb begin
		fire      = (!valid_q || m_tready) && (busy_q || head_valid);
		pop       = fire && !busy_q;
		src_bytes = busy_q ? sh_q  : head_desc.bytes;
		src_rem   = busy_q ? rem_q : head_desc.count;
		src_tot   = busy_q ? tot_q : head_desc.count;
		src_end   = src_rem == 3'd1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sh_q    <= src_bytes >> 8;
			rem_q   <= src_rem - 3'd1;
			tot_q   <= src_tot;
			byte_q  <= src_bytes[7:0];
			last_q  <= src_end;
			total_q <= src_end ? src_tot : 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q  <= !src_end;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = total_q;

endmodule

`default_nettype wire
